// ----- rtl/core/bsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the brick slot allocator
// Sizes, field widths, operation, status and register index codes.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int MAX_BRICKS  = 1024;
	localparam int HANDLE_BITS = 32;

	localparam int HANDLE_W = 32;
	localparam int BYTES_W  = 17;
	localparam int COUNT_W  = 11;
	localparam int LIMIT_W  = BYTES_W + COUNT_W;
	localparam int DEPTH_W  = $clog2(MAX_BRICKS + 1);
	localparam int ADDR_W   = (MAX_BRICKS > 1) ? $clog2(MAX_BRICKS) : 1;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = BYTES_W;

	localparam logic [HANDLE_W-1:0] HANDLE_MASK =
		HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);
	localparam logic [DEPTH_W-1:0] MAX_DEPTH = DEPTH_W'(MAX_BRICKS);
	localparam logic [COUNT_W-1:0] MAX_COUNT =
		(MAX_BRICKS > (2 ** COUNT_W) - 1) ? {COUNT_W{1'b1}} : COUNT_W'(MAX_BRICKS);

	localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(64);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_STACK_FULL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRICK_BYTES = CFG_IDX_W'(0),
		REG_BRICK_COUNT = CFG_IDX_W'(1)
	} reg_idx_t;

	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
		eff_count = (cnt > MAX_COUNT) ? MAX_COUNT : cnt;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/brick_slot_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brick_slot_allocator: fixed-size brick allocator with a LIFO free list
// Allocate pops the last freed handle, else returns the bump offset and
// advances it by the brick size (exhausted past the limit); free pushes a handle onto the stack unless it is full.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// request   in         start & !busy             operation, handle_in
// result    out        done (one cycle)          handle_out, status
// config    in         cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One request per cycle; each result appears with done in the cycle after its
// request is accepted, as the read of the free stack memory is registered.
// busy is never raised and cfg_ready is always high. arst_n clears the bump
// offset, stack depth and result valid flags and reloads the brick size and
// count; the stack memory itself is not cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
module brick_slot_allocator
	import bsa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  operation,
	input  wire logic [HANDLE_W-1:0]   handle_in,
	output logic                       done,
	output logic [HANDLE_W-1:0]        handle_out,
	output logic [1:0]                 status,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BYTES_W-1:0]  bytes_q;
	logic [COUNT_W-1:0]  count_q;
	logic [LIMIT_W-1:0]  limit_q;
	logic [HANDLE_W-1:0] bump_q;
	logic [DEPTH_W-1:0]  depth_q;

	logic [HANDLE_W-1:0] mem [MAX_BRICKS];

	logic                accept;
	logic                is_pop;
	logic                is_push;
	logic                can_bump;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   wr_addr;
	logic [COUNT_W-1:0]  new_count;

	logic                valid_s1;
	logic                pop_s1;
	logic [HANDLE_W-1:0] handle_s1;
	status_t             status_s1;
	logic [HANDLE_W-1:0] rd_data_s1;

	status_t             status_c;
	logic [HANDLE_W-1:0] handle_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	assign is_pop   = (op_t'(operation) == OP_ALLOC) && (depth_q != '0);
	assign is_push  = (op_t'(operation) == OP_FREE) && (depth_q < MAX_DEPTH);
	assign can_bump = {{(HANDLE_W - LIMIT_W){1'b0}}, limit_q} > bump_q;
	assign rd_addr  = ADDR_W'(depth_q - DEPTH_W'(1));
	assign wr_addr  = ADDR_W'(depth_q);
	assign new_count = eff_count(cfg_data[COUNT_W-1:0]);

	always_comb begin
		status_c = ST_OK;
		handle_c = '0;
		if (op_t'(operation) == OP_ALLOC) begin
			if (!is_pop) begin
				if (can_bump) begin
					handle_c = bump_q & HANDLE_MASK;
				end else begin
					status_c = ST_EXHAUSTED;
				end
			end
		end else if (!is_push) begin
			status_c = ST_STACK_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= BYTES_RESET;
			count_q <= COUNT_RESET;
			limit_q <= LIMIT_W'(BYTES_RESET) * LIMIT_W'(eff_count(COUNT_RESET));
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BRICK_BYTES: begin
					bytes_q <= cfg_data[BYTES_W-1:0];
					limit_q <= LIMIT_W'(cfg_data[BYTES_W-1:0]) *
						LIMIT_W'(eff_count(count_q));
				end
				REG_BRICK_COUNT: begin
					count_q <= cfg_data[COUNT_W-1:0];
					limit_q <= LIMIT_W'(bytes_q) * LIMIT_W'(new_count);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_q   <= '0;
			depth_q  <= '0;
			valid_s1 <= 1'b0;
			pop_s1   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			pop_s1   <= accept && is_pop;
			if (accept) begin
				if (is_pop) begin
					depth_q <= depth_q - DEPTH_W'(1);
				end else if (is_push) begin
					depth_q <= depth_q + DEPTH_W'(1);
				end else if (op_t'(operation) == OP_ALLOC && can_bump) begin
					bump_q <= bump_q + {{(HANDLE_W - BYTES_W){1'b0}}, bytes_q};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			handle_s1 <= handle_c;
			status_s1 <= status_c;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_pop) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (accept && is_push) begin
			mem[wr_addr] <= handle_in & HANDLE_MASK;
		end
	end

	assign done       = valid_s1;
	assign handle_out = pop_s1 ? (rd_data_s1 & HANDLE_MASK) : handle_s1;
	assign status     = status_s1;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= MAX_DEPTH)
		else $error("free stack depth beyond capacity");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without a request");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> handle_out == '0)
		else $error("failed request returned a handle");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop_s1 |-> status == ST_OK)
		else $error("stack pop reported a failure");

endmodule
`default_nettype wire
